@@ rtl/m3it_pkg.sv @@
// Package for the 3x3 inverse-transpose unit: defaults, shared types
`timescale 1ns / 1ps

package m3it_pkg;

    // default element format, Q16.16
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // matrix elements per item
    localparam int N_ELEM = 9;

    // depth of the queue between front and back, power of two
    localparam int FIFO_DEPTH = 4;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_flags;

endpackage

@@ rtl/m3it_if.sv @@
// Channel interfaces: matrix items in, result items out
`timescale 1ns / 1ps

interface m3it_mat_if #(
    parameter int W = 32
);
    logic valid;
    logic ready;
    logic signed [W-1:0] e_r0_c0;
    logic signed [W-1:0] e_r0_c1;
    logic signed [W-1:0] e_r0_c2;
    logic signed [W-1:0] e_r1_c0;
    logic signed [W-1:0] e_r1_c1;
    logic signed [W-1:0] e_r1_c2;
    logic signed [W-1:0] e_r2_c0;
    logic signed [W-1:0] e_r2_c1;
    logic signed [W-1:0] e_r2_c2;

    modport source (
        output valid, e_r0_c0, e_r0_c1, e_r0_c2, e_r1_c0, e_r1_c1, e_r1_c2,
               e_r2_c0, e_r2_c1, e_r2_c2,
        input  ready
    );
    modport sink (
        input  valid, e_r0_c0, e_r0_c1, e_r0_c2, e_r1_c0, e_r1_c1, e_r1_c2,
               e_r2_c0, e_r2_c1, e_r2_c2,
        output ready
    );
endinterface

interface m3it_res_if #(
    parameter int W = 32
);
    logic valid;
    logic ready;
    logic signed [W-1:0] q_r0_c0;
    logic signed [W-1:0] q_r0_c1;
    logic signed [W-1:0] q_r0_c2;
    logic signed [W-1:0] q_r1_c0;
    logic signed [W-1:0] q_r1_c1;
    logic signed [W-1:0] q_r1_c2;
    logic signed [W-1:0] q_r2_c0;
    logic signed [W-1:0] q_r2_c1;
    logic signed [W-1:0] q_r2_c2;
    logic singular;
    logic overflowed;

    modport source (
        output valid, q_r0_c0, q_r0_c1, q_r0_c2, q_r1_c0, q_r1_c1, q_r1_c2,
               q_r2_c0, q_r2_c1, q_r2_c2, singular, overflowed,
        input  ready
    );
    modport sink (
        input  valid, q_r0_c0, q_r0_c1, q_r0_c2, q_r1_c0, q_r1_c1, q_r1_c2,
               q_r2_c0, q_r2_c1, q_r2_c2, singular, overflowed,
        output ready
    );
endinterface

@@ rtl/m3it_front.sv @@
// Front: accepts matrices, forms cofactors and determinant, flags singular
`timescale 1ns / 1ps

module m3it_front import m3it_pkg::*; #(
    parameter int W  = DATA_WIDTH_DEF,
    parameter int CW = 2 * W + 1,
    parameter int DW = 3 * W + 3,
    parameter int QW = N_ELEM * CW + DW + 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    m3it_mat_if.sink        i_mat,
    input  t_fifo_flags     i_flags,
    output logic            o_push,
    output logic [QW-1:0]   o_data
);

    logic signed [W-1:0] e [N_ELEM];
    logic                en;

    // stage valid bits
    logic [3:0] r_v;

    // stage 1: cofactor product pairs
    logic signed [2*W-1:0] r_pa [N_ELEM];
    logic signed [2*W-1:0] r_pb [N_ELEM];
    logic signed [W-1:0]   r_e1 [3];
    // stage 2: cofactors
    logic signed [CW-1:0]  r_cof2 [N_ELEM];
    logic signed [W-1:0]   r_e2 [3];
    // stage 3: partial products of the row-0 expansion
    logic signed [CW-1:0]  r_cof3 [N_ELEM];
    logic signed [CW-1:0]  r_plo [3];
    logic signed [CW-1:0]  r_phi [3];
    // stage 4: determinant
    logic signed [CW-1:0]  r_cof4 [N_ELEM];
    logic signed [DW-1:0]  r_det;
    logic                  r_sing;

    logic signed [2*W-1:0] n_pa [N_ELEM];
    logic signed [2*W-1:0] n_pb [N_ELEM];
    logic signed [CW-1:0]  n_cof [N_ELEM];
    logic signed [CW-1:0]  n_plo [3];
    logic signed [CW-1:0]  n_phi [3];
    logic signed [DW-1:0]  n_det;

    assign e[0] = i_mat.e_r0_c0;
    assign e[1] = i_mat.e_r0_c1;
    assign e[2] = i_mat.e_r0_c2;
    assign e[3] = i_mat.e_r1_c0;
    assign e[4] = i_mat.e_r1_c1;
    assign e[5] = i_mat.e_r1_c2;
    assign e[6] = i_mat.e_r2_c0;
    assign e[7] = i_mat.e_r2_c1;
    assign e[8] = i_mat.e_r2_c2;

    // whole front advances unless its last item cannot enter the queue
    assign en          = !r_v[3] || !i_flags.full;
    assign i_mat.ready = en;
    assign o_push      = r_v[3] && !i_flags.full;

    // minor products and signed cofactors
    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            localparam int R1 = (gi == 0) ? 1 : 0;
            localparam int R2 = (gi == 2) ? 1 : 2;
            localparam int C1 = (gj == 0) ? 1 : 0;
            localparam int C2 = (gj == 2) ? 1 : 2;
            localparam int N  = gi * 3 + gj;
            assign n_pa[N] = e[R1*3+C1] * e[R2*3+C2];
            assign n_pb[N] = e[R1*3+C2] * e[R2*3+C1];
            if (((gi + gj) % 2) == 1) begin : g_odd
                assign n_cof[N] = CW'(r_pb[N]) - CW'(r_pa[N]);
            end else begin : g_even
                assign n_cof[N] = CW'(r_pa[N]) - CW'(r_pb[N]);
            end
        end
    end

    // cofactor split in low (unsigned) and high (signed) halves
    for (genvar gk = 0; gk < 3; gk++) begin : g_part
        assign n_plo[gk] = r_e2[gk] * $signed({1'b0, r_cof2[gk][W-1:0]});
        assign n_phi[gk] = r_e2[gk] * $signed(r_cof2[gk][CW-1:W]);
    end

    // determinant by expansion along row 0
    always_comb begin
        n_det = '0;
        for (int k = 0; k < 3; k++) begin
            n_det = n_det + (DW'(r_phi[k]) <<< W) + DW'(r_plo[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[2:0], i_mat.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa   <= n_pa;
            r_pb   <= n_pb;
            r_e1   <= '{e[0], e[1], e[2]};
            r_cof2 <= n_cof;
            r_e2   <= r_e1;
            r_cof3 <= r_cof2;
            r_plo  <= n_plo;
            r_phi  <= n_phi;
            r_cof4 <= r_cof3;
            r_det  <= n_det;
            r_sing <= (n_det == '0);
        end
    end

    // pack for the queue: cofactors, determinant, singular on top
    always_comb begin
        o_data = '0;
        for (int n = 0; n < N_ELEM; n++) begin
            o_data[n*CW +: CW] = r_cof4[n];
        end
        o_data[N_ELEM*CW +: DW] = r_det;
        o_data[QW-1]            = r_sing;
    end

endmodule

@@ rtl/m3it_fifo.sv @@
// Short queue between front and back
`timescale 1ns / 1ps

module m3it_fifo import m3it_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_fifo_flags      o_flags
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;

    assign o_data        = r_mem[r_rp];
    assign o_flags.full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_flags.empty = (r_cnt == '0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/m3it_back.sv @@
// Back: pipelined restoring division of nine cofactors, saturation, output
`timescale 1ns / 1ps

module m3it_back import m3it_pkg::*; #(
    parameter int W  = DATA_WIDTH_DEF,
    parameter int F  = FRAC_BITS_DEF,
    parameter int CW = 2 * W + 1,
    parameter int DW = 3 * W + 3,
    parameter int QW = N_ELEM * CW + DW + 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [QW-1:0]   i_data,
    input  t_fifo_flags     i_flags,
    output logic            o_pop,
    m3it_res_if.source      o_res
);

    // remainder width covers both the shifted numerator and divisor << (W+1)
    localparam int RW = (4*W + 2 > 2*W + 2*F + 2) ? 4*W + 2 : 2*W + 2*F + 2;
    // stage 0 load, stage 1 overflow check, then one quotient bit a stage
    localparam int NS = W + 3;

    logic en;

    logic              r_v   [NS];
    logic [RW-1:0]     r_rem [NS][N_ELEM];
    logic [W:0]        r_q   [NS][N_ELEM];
    logic              r_neg [NS][N_ELEM];
    logic              r_ovf [NS][N_ELEM];
    logic [RW-1:0]     r_dm  [NS];
    logic              r_sg  [NS];

    logic [RW-1:0]     n_rem [NS][N_ELEM];
    logic [W:0]        n_q   [NS][N_ELEM];
    logic              n_neg [NS][N_ELEM];
    logic              n_ovf [NS][N_ELEM];
    logic [RW-1:0]     n_dm  [NS];
    logic              n_sg  [NS];

    // output register
    logic              r_ov;
    logic [W-1:0]      r_qo [N_ELEM];
    logic              r_sing;
    logic              r_oflw;
    logic [W-1:0]      n_qo [N_ELEM];
    logic              n_oflw;

    logic signed [DW-1:0] det;
    logic [DW-1:0]        det_mag;

    assign en    = !r_ov || o_res.ready;
    assign o_pop = en && !i_flags.empty;

    // load: magnitudes and quotient signs
    assign det     = $signed(i_data[N_ELEM*CW +: DW]);
    assign det_mag = det[DW-1] ? (~det + 1'b1) : det;
    assign n_dm[0] = RW'(det_mag);
    assign n_sg[0] = i_data[QW-1];

    for (genvar gn = 0; gn < N_ELEM; gn++) begin : g_load
        logic [CW-1:0] cof;
        logic [CW-1:0] cof_mag;
        assign cof          = i_data[gn*CW +: CW];
        assign cof_mag      = cof[CW-1] ? (~cof + 1'b1) : cof;
        assign n_rem[0][gn] = RW'(cof_mag) << (2 * F);
        assign n_q[0][gn]   = '0;
        assign n_neg[0][gn] = cof[CW-1] ^ det[DW-1];
        assign n_ovf[0][gn] = 1'b0;
    end

    // overflow check: quotient at or above 2^(W+1)
    assign n_dm[1] = r_dm[0];
    assign n_sg[1] = r_sg[0];
    for (genvar gn = 0; gn < N_ELEM; gn++) begin : g_ovf
        assign n_rem[1][gn] = r_rem[0][gn];
        assign n_q[1][gn]   = r_q[0][gn];
        assign n_neg[1][gn] = r_neg[0][gn];
        assign n_ovf[1][gn] = (r_rem[0][gn] >= (r_dm[0] << (W + 1)));
    end

    // one quotient bit per stage, most significant first
    for (genvar gs = 2; gs < NS; gs++) begin : g_stage
        localparam int K = W + 2 - gs;
        assign n_dm[gs] = r_dm[gs-1];
        assign n_sg[gs] = r_sg[gs-1];
        for (genvar gn = 0; gn < N_ELEM; gn++) begin : g_elem
            logic [RW-1:0] dsh;
            logic          ge;
            assign dsh           = r_dm[gs-1] << K;
            assign ge            = (r_rem[gs-1][gn] >= dsh);
            assign n_rem[gs][gn] = ge ? (r_rem[gs-1][gn] - dsh) : r_rem[gs-1][gn];
            assign n_q[gs][gn]   = r_q[gs-1][gn] | ((W+1)'(ge) << K);
            assign n_neg[gs][gn] = r_neg[gs-1][gn];
            assign n_ovf[gs][gn] = r_ovf[gs-1][gn];
        end
    end

    // saturate, apply sign, zero a singular item
    always_comb begin
        logic [W:0] lim;
        logic       sat;
        lim    = (W+1)'(1) << (W - 1);
        n_oflw = 1'b0;
        for (int n = 0; n < N_ELEM; n++) begin
            sat = r_ovf[NS-1][n] ||
                  (r_neg[NS-1][n] ? (r_q[NS-1][n] > lim) : (r_q[NS-1][n] >= lim));
            if (r_sg[NS-1]) begin
                n_qo[n] = '0;
            end else if (sat) begin
                n_qo[n] = r_neg[NS-1][n] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                n_oflw  = 1'b1;
            end else begin
                n_qo[n] = r_neg[NS-1][n] ? (~r_q[NS-1][n][W-1:0] + 1'b1)
                                         : r_q[NS-1][n][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_v[s] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_flags.empty;
            for (int s = 1; s < NS; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_ov <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem  <= n_rem;
            r_q    <= n_q;
            r_neg  <= n_neg;
            r_ovf  <= n_ovf;
            r_dm   <= n_dm;
            r_sg   <= n_sg;
            r_qo   <= n_qo;
            r_sing <= r_sg[NS-1];
            r_oflw <= n_oflw && !r_sg[NS-1];
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.q_r0_c0    = r_qo[0];
    assign o_res.q_r0_c1    = r_qo[1];
    assign o_res.q_r0_c2    = r_qo[2];
    assign o_res.q_r1_c0    = r_qo[3];
    assign o_res.q_r1_c1    = r_qo[4];
    assign o_res.q_r1_c2    = r_qo[5];
    assign o_res.q_r2_c0    = r_qo[6];
    assign o_res.q_r2_c1    = r_qo[7];
    assign o_res.q_r2_c2    = r_qo[8];
    assign o_res.singular   = r_sing;
    assign o_res.overflowed = r_oflw;

endmodule

@@ rtl/matrix3_inverse_transpose.sv @@
// Top level of the 3x3 inverse-transpose (normal matrix) unit
//
//  channel  dir  port    item
//  -------  ---  ------  ------------------------------------------------
//  matrix   in   i_mat   nine signed fixed-point elements e_r0_c0..e_r2_c2
//  result   out  o_res   nine elements q_r0_c0..q_r2_c2, singular, overflowed
//
// One item per cycle sustained while o_res is ready; an item passes through 4
// front stages, the queue, DATA_WIDTH+3 divider stages, the output register.
// The nine long divisions run as a restoring divider, one quotient bit a stage.
// Reset clears valid bits, queue pointers and count only; no clearing pass.
// Front and back stall independently; the queue absorbs a stalled output.
`timescale 1ns / 1ps

module matrix3_inverse_transpose import m3it_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    m3it_mat_if.sink    i_mat,
    m3it_res_if.source  o_res
);

    localparam int CW = 2 * DATA_WIDTH + 1;
    localparam int DW = 3 * DATA_WIDTH + 3;
    localparam int QW = N_ELEM * CW + DW + 1;

    logic          push;
    logic          pop;
    logic [QW-1:0] push_data;
    logic [QW-1:0] pop_data;
    t_fifo_flags   flags;

    m3it_front #(
        .W  (DATA_WIDTH),
        .CW (CW),
        .DW (DW),
        .QW (QW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (i_mat),
        .i_flags (flags),
        .o_push  (push),
        .o_data  (push_data)
    );

    m3it_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_flags (flags)
    );

    m3it_back #(
        .W  (DATA_WIDTH),
        .F  (FRAC_BITS),
        .CW (CW),
        .DW (DW),
        .QW (QW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (pop_data),
        .i_flags (flags),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
